[hw/rtl/rrcc_pkg.sv]
// Shared types, constants and functions of the random-replacement content cache.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rrcc_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int NAME_BITS  = 32;
  localparam int CHUNK_BITS = 16;
  localparam int KB_W       = 7;
  localparam int CAP_W      = 16;
  localparam int SIZE_W     = 16;
  localparam int LFSR_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int STATUS_W   = 2;

  // size / 1000 as (size * 67109) >> 26, exact for all 16-bit sizes
  localparam logic [16:0] KB_RECIP = 17'd67109;
  localparam int          KB_SHIFT = 26;
  localparam int          PROD_W   = SIZE_W + 17;

  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 32'h0000_0001;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CACHED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOOLARGE = 2'd3;

  typedef struct packed {
    logic [NAME_BITS-1:0]  name;
    logic [CHUNK_BITS-1:0] chunk;
    logic [KB_W-1:0]       kb;
  } slot_entry_t;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] remainder;
  } mod_rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

[hw/rtl/rrcc_if.sv]
// Handshake channels of the cache: request items, result items, register writes.
// Depends on rrcc_pkg for field widths.
`timescale 1ns / 1ps

interface rrcc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [31:0]                     content_id;
  logic [15:0]                     chunk_index;
  logic [rrcc_pkg::SIZE_W-1:0]     size_bytes;
  modport source (output valid, command, content_id, chunk_index, size_bytes, input ready);
  modport sink (input valid, command, content_id, chunk_index, size_bytes, output ready);
endinterface

interface rrcc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [rrcc_pkg::STATUS_W-1:0]   status;
  logic [6:0]                      evicted;
  logic [rrcc_pkg::CAP_W-1:0]      used_kb;
  modport source (output valid, hit, status, evicted, used_kb, input ready);
  modport sink (input valid, hit, status, evicted, used_kb, output ready);
endinterface

interface rrcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rrcc_pkg::CFG_IDX_W-1:0]    index;
  logic [rrcc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/random_replacement_content_cache.sv]
// Top level of the random-replacement content cache: sequencer, valid bits,
// counters and LFSR. Depends on rrcc_pkg, rrcc_if, rrcc_mem and rrcc_mod.
`timescale 1ns / 1ps

// One item is worked at a time. Each item first scans all 64 slots through the
// payload memory, one read a cycle with registered read data, then decides. An
// insert then makes each eviction by an LFSR advance, the 32-step serial modulo
// by the occupied count, a walk over the valid bits to the chosen slot, and a read
// of its kB size. It then walks to the lowest free slot and hands the result to
// the output register; the next item is taken once that register is loaded.
// Register writes are taken at any time and act at once; write them only
// while the block is idle. There is no clearing pass after reset.
module random_replacement_content_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrcc_in_if.sink     in_i,
  rrcc_out_if.source  out_o,
  rrcc_cfg_if.sink    cfg_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_EVCHK  = 4'd3;
  localparam logic [3:0] S_MOD    = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_KBRD   = 4'd6;
  localparam logic [3:0] S_PLACE  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  localparam int IW = rrcc_pkg::IDX_W;
  localparam int CW = rrcc_pkg::CNT_W;
  localparam int KW = rrcc_pkg::KB_W;
  localparam int UW = rrcc_pkg::CAP_W;

  logic [3:0]                   state_q, state_d;
  logic [rrcc_pkg::ENTRIES-1:0] valid_q, valid_d;
  logic [UW-1:0]                used_q, used_d;
  logic [CW-1:0]                occ_q, occ_d;
  logic [rrcc_pkg::LFSR_W-1:0]  lfsr_q, lfsr_d;
  logic [UW-1:0]                cap_q, cap_d;
  logic [CW-1:0]                rd_idx_q, rd_idx_d;
  logic [IW-1:0]                cmp_idx_q, cmp_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]                walk_q, walk_d;
  logic [CW-1:0]                seen_q, seen_d;
  logic [CW-1:0]                k_q, k_d;
  logic                         hit_q, hit_d;
  logic [6:0]                   evict_q, evict_d;
  logic [rrcc_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         out_vld_q, out_vld_d;

  // item payload, held for the whole item
  logic                          cmd_q, cmd_d;
  logic [rrcc_pkg::NAME_BITS-1:0]  name_q, name_d;
  logic [rrcc_pkg::CHUNK_BITS-1:0] chunk_q, chunk_d;
  logic [KW-1:0]                 kb_q, kb_d;

  logic                          o_hit_q, o_hit_d;
  logic [rrcc_pkg::STATUS_W-1:0] o_status_q, o_status_d;
  logic [6:0]                    o_evict_q, o_evict_d;
  logic [UW-1:0]                 o_used_q, o_used_d;

  logic                          in_fire;
  logic [rrcc_pkg::PROD_W-1:0]   kb_prod;
  logic [UW:0]                   need;
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr, mem_raddr;
  rrcc_pkg::slot_entry_t         mem_wdata, mem_rdata;
  rrcc_pkg::mod_req_t            mod_req;
  rrcc_pkg::mod_rsp_t            mod_rsp;

  rrcc_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rrcc_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // kB size by reciprocal multiply
  assign kb_prod = {{(rrcc_pkg::PROD_W-rrcc_pkg::SIZE_W){1'b0}}, in_i.size_bytes}
                 * {{(rrcc_pkg::PROD_W-17){1'b0}}, rrcc_pkg::KB_RECIP};
  assign need    = {1'b0, used_q} + {{(UW+1-KW){1'b0}}, kb_q};

  assign mem_wdata.name  = name_q;
  assign mem_wdata.chunk = chunk_q;
  assign mem_wdata.kb    = kb_q;
  assign mem_waddr       = walk_q;
  assign mem_raddr       = (state_q == S_SCAN) ? rd_idx_q[IW-1:0] : walk_q;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    used_d     = used_q;
    occ_d      = occ_q;
    lfsr_d     = lfsr_q;
    cap_d      = cap_q;
    rd_idx_d   = rd_idx_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    walk_d     = walk_q;
    seen_d     = seen_q;
    k_d        = k_q;
    hit_d      = hit_q;
    evict_d    = evict_q;
    status_d   = status_q;
    out_vld_d  = out_vld_q;
    cmd_d      = cmd_q;
    name_d     = name_q;
    chunk_d    = chunk_q;
    kb_d       = kb_q;
    o_hit_d    = o_hit_q;
    o_status_d = o_status_q;
    o_evict_d  = o_evict_q;
    o_used_d   = o_used_q;
    mem_we     = 1'b0;
    mod_req    = '0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    // register writes; a zero seed loads as one so the LFSR never locks up
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rrcc_pkg::REG_CAPACITY: cap_d = cfg_i.data[UW-1:0];
        rrcc_pkg::REG_SEED: begin
          lfsr_d = (cfg_i.data == '0) ? rrcc_pkg::LFSR_RESET : cfg_i.data;
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d    = in_i.command;
          name_d   = in_i.content_id[rrcc_pkg::NAME_BITS-1:0];
          chunk_d  = in_i.chunk_index[rrcc_pkg::CHUNK_BITS-1:0];
          kb_d     = kb_prod[rrcc_pkg::KB_SHIFT +: KW];
          hit_d    = 1'b0;
          evict_d  = '0;
          status_d = rrcc_pkg::ST_OK;
          rd_idx_d = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, compare the slot whose read was issued in the previous cycle
        if (rd_idx_q < CW'(rrcc_pkg::ENTRIES)) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_idx_d = rd_idx_q[IW-1:0];
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q) begin
          if (valid_q[cmp_idx_q] && mem_rdata.name == name_q
              && mem_rdata.chunk == chunk_q) begin
            hit_d = 1'b1;
          end
          if (cmp_idx_q == IW'(rrcc_pkg::ENTRIES - 1)) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        priority if (cmd_q == rrcc_pkg::CMD_LOOKUP) begin
          state_d = S_FINISH;
        end else if (cap_q == '0) begin
          status_d = rrcc_pkg::ST_DISABLED;
          state_d  = S_FINISH;
        end else if (hit_q) begin
          status_d = rrcc_pkg::ST_CACHED;
          state_d  = S_FINISH;
        end else if ({{(UW-KW){1'b0}}, kb_q} > cap_q) begin
          status_d = rrcc_pkg::ST_TOOLARGE;
          state_d  = S_FINISH;
        end else begin
          state_d = S_EVCHK;
        end
      end
      S_EVCHK: begin
        // evict while over capacity, and once more if every slot is taken
        if ((need > {1'b0, cap_q} && occ_q != '0)
            || occ_q == CW'(rrcc_pkg::ENTRIES)) begin
          lfsr_d           = rrcc_pkg::lfsr_step(lfsr_q);
          mod_req.start    = 1'b1;
          mod_req.dividend = rrcc_pkg::lfsr_step(lfsr_q);
          mod_req.divisor  = occ_q;
          state_d          = S_MOD;
        end else begin
          walk_d  = '0;
          state_d = S_PLACE;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          k_d     = mod_rsp.remainder;
          walk_d  = '0;
          seen_d  = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // count valid slots up to the chosen one, read its size
        if (valid_q[walk_q]) begin
          if (seen_q == k_q) begin
            valid_d[walk_q] = 1'b0;
            occ_d           = occ_q - 1'b1;
            evict_d         = evict_q + 1'b1;
            state_d         = S_KBRD;
          end else begin
            seen_d = seen_q + 1'b1;
            walk_d = walk_q + 1'b1;
          end
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_KBRD: begin
        if (used_q >= {{(UW-KW){1'b0}}, mem_rdata.kb}) begin
          used_d = used_q - {{(UW-KW){1'b0}}, mem_rdata.kb};
        end else begin
          used_d = '0;
        end
        state_d = S_EVCHK;
      end
      S_PLACE: begin
        // store into the lowest free slot
        if (!valid_q[walk_q]) begin
          mem_we          = 1'b1;
          valid_d[walk_q] = 1'b1;
          occ_d           = occ_q + 1'b1;
          used_d          = need[UW-1:0];
          state_d         = S_FINISH;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          o_hit_d    = hit_q;
          o_status_d = status_q;
          o_evict_d  = evict_q;
          o_used_d   = used_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      used_q    <= '0;
      occ_q     <= '0;
      lfsr_q    <= rrcc_pkg::LFSR_RESET;
      cap_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      used_q    <= used_d;
      occ_q     <= occ_d;
      lfsr_q    <= lfsr_d;
      cap_q     <= cap_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    walk_q     <= walk_d;
    seen_q     <= seen_d;
    k_q        <= k_d;
    hit_q      <= hit_d;
    evict_q    <= evict_d;
    status_q   <= status_d;
    cmd_q      <= cmd_d;
    name_q     <= name_d;
    chunk_q    <= chunk_d;
    kb_q       <= kb_d;
    o_hit_q    <= o_hit_d;
    o_status_q <= o_status_d;
    o_evict_q  <= o_evict_d;
    o_used_q   <= o_used_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.hit     = o_hit_q;
  assign out_o.status  = o_status_q;
  assign out_o.evicted = o_evict_q;
  assign out_o.used_kb = o_used_q;

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CW'($countones(valid_q)))
    else $error("occupied count differs from valid bits");

  a_victim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && mod_rsp.done) |-> (mod_rsp.remainder < occ_q))
    else $error("victim rank not below occupied count");

  a_place_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |-> (occ_q < CW'(rrcc_pkg::ENTRIES)))
    else $error("placing into a full cache");
`endif

endmodule

[hw/rtl/rrcc_mem.sv]
// Slot payload store: name, chunk and kB size of each slot, one write and
// one registered read per cycle. Depends on rrcc_pkg.
`timescale 1ns / 1ps

module rrcc_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [rrcc_pkg::IDX_W-1:0]   waddr_i,
  input  rrcc_pkg::slot_entry_t        wdata_i,
  input  logic [rrcc_pkg::IDX_W-1:0]   raddr_i,
  output rrcc_pkg::slot_entry_t        rdata_o
);

  rrcc_pkg::slot_entry_t mem_q [rrcc_pkg::ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/rrcc_mod.sv]
// Bit-serial restoring modulo: 32-bit LFSR value mod occupied count.
// One dividend bit per cycle. Depends on rrcc_pkg.
`timescale 1ns / 1ps

module rrcc_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrcc_pkg::mod_req_t   req_i,
  output rrcc_pkg::mod_rsp_t   rsp_o
);

  localparam int REM_W = rrcc_pkg::CNT_W + 1;
  localparam int BIT_W = $clog2(rrcc_pkg::LFSR_W + 1);

  logic                         busy_q, busy_d;
  logic [BIT_W-1:0]             bits_q, bits_d;
  logic [rrcc_pkg::LFSR_W-1:0]  dvd_q, dvd_d;
  logic [rrcc_pkg::CNT_W-1:0]   dvs_q, dvs_d;
  logic [REM_W-1:0]             rem_q, rem_d;
  logic                         done_q, done_d;
  logic [REM_W-1:0]             trial;

  always_comb begin
    busy_d = busy_q;
    bits_d = bits_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q[REM_W-2:0], dvd_q[rrcc_pkg::LFSR_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      bits_d = BIT_W'(rrcc_pkg::LFSR_W);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
      end else begin
        rem_d = trial;
      end
      bits_d = bits_q - 1'b1;
      if (bits_q == BIT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bits_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      bits_q <= bits_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q[rrcc_pkg::CNT_W-1:0];

endmodule

[sim/tb_random_replacement_content_cache.sv]
// Self-checking testbench of the random-replacement content cache: directed table, then
// random phases over several capacity and seed settings. Depends on rrcc_pkg, rrcc_if and the cache top level.
`timescale 1ns / 1ps

module tb_random_replacement_content_cache;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int KEY_POOL    = 96;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic                          hit;
    logic [rrcc_pkg::STATUS_W-1:0] status;
    logic [6:0]                    evicted;
    logic [rrcc_pkg::CAP_W-1:0]    used_kb;
  } cache_reply_t;

  // One row of the directed table: either a register write (is_cfg) or an item.
  // For a register write, cmd holds the register index and val the data.
  typedef struct {
    logic                          is_cfg;
    logic                          cmd;
    logic [31:0]                   id;
    logic [15:0]                   chunk;
    logic [31:0]                   val;
    logic                          typed;
    logic                          hit;
    logic [rrcc_pkg::STATUS_W-1:0] status;
    logic [6:0]                    evicted;
    logic [rrcc_pkg::CAP_W-1:0]    used_kb;
  } table_row_t;

  logic clk_i;
  logic rst_ni;

  rrcc_in_if  in_if ();
  rrcc_out_if out_if ();
  rrcc_cfg_if cfg_if ();

  random_replacement_content_cache u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the cache contents and registers.
  logic                          sh_valid [rrcc_pkg::ENTRIES];
  logic [31:0]                   sh_name  [rrcc_pkg::ENTRIES];
  logic [15:0]                   sh_chunk [rrcc_pkg::ENTRIES];
  logic [rrcc_pkg::KB_W-1:0]     sh_kb    [rrcc_pkg::ENTRIES];
  int unsigned                   sh_used;
  int unsigned                   sh_count;
  logic [31:0]                   sh_lfsr;
  logic [rrcc_pkg::CAP_W-1:0]    sh_cap;

  cache_reply_t      pending_replies[$];
  int                errors;
  int                cycles;
  int                replies_seen;
  int                evict_total;
  bit                quiet;

  logic [31:0]       pool_id    [KEY_POOL];
  logic [15:0]       pool_chunk [KEY_POOL];

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long; none at all in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet) return 0;
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(200, 20);
  endfunction

  // Advance the shadow LFSR and drop the chosen valid entry.
  task automatic evict_one();
    int unsigned k;
    int unsigned seen;
    logic [31:0] s;
    if (sh_count == 0) return;
    s = sh_lfsr >> 1;
    if (sh_lfsr[0]) s = s ^ rrcc_pkg::LFSR_TAPS;
    sh_lfsr = s;
    k = sh_lfsr % sh_count;
    seen = 0;
    for (int i = 0; i < rrcc_pkg::ENTRIES; i++) begin
      if (sh_valid[i]) begin
        if (seen == k) begin
          sh_valid[i] = 1'b0;
          sh_used = (sh_used >= sh_kb[i]) ? sh_used - sh_kb[i] : 0;
          sh_count--;
          return;
        end
        seen++;
      end
    end
  endtask

  // Work out the reply of one item and update the shadow state.
  task automatic predict_access(input logic cmd, input logic [31:0] id,
                                input logic [15:0] chunk, input logic [15:0] size,
                                output cache_reply_t rep);
    int unsigned kb;
    int unsigned ev;
    logic found;
    kb = size / 1000;
    ev = 0;
    found = 1'b0;
    for (int i = 0; i < rrcc_pkg::ENTRIES; i++)
      if (sh_valid[i] && sh_name[i] == id && sh_chunk[i] == chunk) found = 1'b1;
    rep.status = rrcc_pkg::ST_OK;
    if (cmd == rrcc_pkg::CMD_INSERT) begin
      if (sh_cap == 0) rep.status = rrcc_pkg::ST_DISABLED;
      else if (found) rep.status = rrcc_pkg::ST_CACHED;
      else if (kb > sh_cap) rep.status = rrcc_pkg::ST_TOOLARGE;
      else begin
        while (sh_used + kb > sh_cap && sh_count > 0) begin
          evict_one();
          ev++;
        end
        if (sh_count >= rrcc_pkg::ENTRIES) begin
          evict_one();
          ev++;
        end
        for (int i = 0; i < rrcc_pkg::ENTRIES; i++) begin
          if (!sh_valid[i]) begin
            sh_valid[i] = 1'b1;
            sh_name[i]  = id;
            sh_chunk[i] = chunk;
            sh_kb[i]    = kb[rrcc_pkg::KB_W-1:0];
            sh_used     = sh_used + kb;
            sh_count++;
            break;
          end
        end
      end
    end
    rep.hit     = found;
    rep.evicted = ev[6:0];
    rep.used_kb = sh_used[rrcc_pkg::CAP_W-1:0];
    evict_total += ev;
  endtask

  // Present one item at the falling edge and hold it until taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic cmd, input logic [31:0] id, input logic [15:0] chunk,
                           input logic [15:0] size, input bit typed,
                           input cache_reply_t typed_rep);
    int gap;
    cache_reply_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.command     = cmd;
    in_if.content_id  = id;
    in_if.chunk_index = chunk;
    in_if.size_bytes  = size;
    in_if.valid       = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    predict_access(cmd, id, chunk, size, rep);
    if (typed) begin
      pending_replies = {pending_replies, typed_rep};
    end else begin
      pending_replies = {pending_replies, rep};
    end
    @(negedge clk_i);
  endtask

  // Write one register, only once the block has drained.
  task automatic write_reg(input logic [rrcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    in_if.valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data  = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == rrcc_pkg::REG_CAPACITY) sh_cap = data[rrcc_pkg::CAP_W-1:0];
    else sh_lfsr = (data == 0) ? 32'd1 : data;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Result side: stall at random, driven at the falling edge.
  int stall_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready = 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      stall_left   = pick_gap();
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_replies.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (out_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_if.hit);
          errors++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, out_if.evicted);
          errors++;
        end
        if (out_if.used_kb !== want.used_kb) begin
          $error("used_kb: expected %0d, got %0d", want.used_kb, out_if.used_kb);
          errors++;
        end
      end
    end
  end

  table_row_t   directed [$];
  cache_reply_t typed_rep;
  cache_reply_t no_rep;
  logic [15:0]  cap_list  [8];
  logic [31:0]  seed_list [8];
  logic         cmd;
  logic [31:0]  id;
  logic [15:0]  chunk;
  logic [15:0]  size;
  int           pick;
  int           span;

  initial begin
    errors       = 0;
    cycles       = 0;
    replies_seen = 0;
    evict_total  = 0;
    quiet        = 1'b0;
    no_rep       = '{1'b0, rrcc_pkg::ST_OK, 7'd0, 16'd0};
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.command      = rrcc_pkg::CMD_LOOKUP;
    in_if.content_id   = '0;
    in_if.chunk_index  = '0;
    in_if.size_bytes   = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = rrcc_pkg::REG_CAPACITY;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    sh_used  = 0;
    sh_count = 0;
    sh_lfsr  = 32'd1;
    sh_cap   = '0;
    for (int i = 0; i < rrcc_pkg::ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_name[i]  = '0;
      sh_chunk[i] = '0;
      sh_kb[i]    = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_id[i]    = $urandom();
      pool_chunk[i] = 16'($urandom_range(16'hFFFF));
    end

    // Directed rows. Capacity starts at zero, so inserts are disabled first.
    directed = '{
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h0, 16'h0, 32'd0, 1'b1, 1'b0,
        rrcc_pkg::ST_DISABLED, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b1, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b1, rrcc_pkg::REG_CAPACITY, 32'h0, 16'h0, 32'd5, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'd65535, 1'b1, 1'b0,
        rrcc_pkg::ST_TOOLARGE, 7'd0, 16'd0},
      // zero-kB chunk still takes a slot
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h1, 16'h2, 32'd999, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h1, 16'h2, 32'd999, 1'b1, 1'b1,
        rrcc_pkg::ST_CACHED, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_LOOKUP, 32'h1, 16'h2, 32'd0, 1'b1, 1'b1,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h3, 16'h4, 32'd5000, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h5, 16'h6, 32'd1000, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      // zero seed loads as one
      '{1'b1, rrcc_pkg::REG_SEED, 32'h0, 16'h0, 32'd0, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h7, 16'h8, 32'd4999, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      // capacity lowered below usage: the next insert evicts
      '{1'b1, rrcc_pkg::REG_CAPACITY, 32'h0, 16'h0, 32'd1, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_LOOKUP, 32'h5, 16'h6, 32'd0, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h9, 16'h9, 32'd0, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b1, rrcc_pkg::REG_CAPACITY, 32'h0, 16'h0, 32'd65535, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b1, rrcc_pkg::REG_SEED, 32'h0, 16'h0, 32'hFFFF_FFFF, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'h0, 16'h0, 32'd65535, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0, 32'd64999, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_LOOKUP, 32'h0, 16'hFFFF, 32'd0, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0},
      '{1'b0, rrcc_pkg::CMD_LOOKUP, 32'h0, 16'h0, 32'd0, 1'b0, 1'b0,
        rrcc_pkg::ST_OK, 7'd0, 16'd0}
    };

    // Hold reset, release at a falling edge.
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[r]) begin
      if (directed[r].is_cfg) begin
        write_reg(directed[r].cmd, directed[r].val);
      end else begin
        typed_rep = '{directed[r].hit, directed[r].status, directed[r].evicted,
                      directed[r].used_kb};
        send_item(directed[r].cmd, directed[r].id, directed[r].chunk,
                  directed[r].val[15:0], directed[r].typed, typed_rep);
      end
    end

    // Random phases: each picks a capacity and seed, extremes among them.
    cap_list  = '{16'd0, 16'd65535, 16'd1, 16'd20, 16'd200, 16'd0, 16'd3, 16'd65535};
    seed_list = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000};
    cap_list[5] = 16'($urandom_range(16'hFFFF, 1));
    for (int p = 2; p < 7; p++) seed_list[p] = (p == 2) ? 32'd1 : $urandom();

    for (int p = 0; p < 8; p++) begin
      write_reg(rrcc_pkg::REG_CAPACITY, {16'd0, cap_list[p]});
      write_reg(rrcc_pkg::REG_SEED, seed_list[p]);
      quiet = (p == 3);
      span  = (cap_list[p] == 0) ? 1 : int'(cap_list[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(99) < 30) ? rrcc_pkg::CMD_LOOKUP : rrcc_pkg::CMD_INSERT;
        if ($urandom_range(99) < 80) begin
          pick  = $urandom_range(KEY_POOL - 1);
          id    = pool_id[pick];
          chunk = pool_chunk[pick];
        end else begin
          id    = $urandom();
          chunk = 16'($urandom_range(16'hFFFF));
        end
        pick = $urandom_range(99);
        // Last phase fills all slots with zero-kB chunks to force the full-cache eviction.
        if (p == 7 || pick < 40) size = 16'($urandom_range(999));
        else if (pick < 85)
          size = 16'($urandom_range((span * 1000 > 65535) ? 65535 : span * 1000));
        else size = 16'($urandom_range(16'hFFFF));
        send_item(cmd, id, chunk, size, 1'b0, no_rep);
      end
    end
    in_if.valid = 1'b0;

    // Drain, then allow the block's latency to pass.
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (pending_replies.size() != 0) begin
      $error("%0d expected results never arrived", pending_replies.size());
      errors++;
    end

    $display("Checked %0d results over 8 capacity/seed phases, %0d evictions predicted.",
             replies_seen, evict_total);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
